@@ rtl/core/ordered_array_list_engine_top_macros.svh @@
// Assertion helpers for the ordered array list engine
`ifndef ORDERED_ARRAY_LIST_ENGINE_TOP_MACROS_SVH
`define ORDERED_ARRAY_LIST_ENGINE_TOP_MACROS_SVH

// same-cycle implication
`define OALE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OALE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/oale_pkg.sv @@
package oale_pkg;

    localparam int IDX_W      = 7;
    localparam int OP_W       = 4;
    localparam int POS_W      = 6;
    localparam int IN_VALUE_W = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 6;
    localparam int EIDX_W     = 5;
    localparam int OUT_ELEM_W = 32;
    localparam int READ_LIMIT = 32;

    typedef enum logic [OP_W-1:0] {
        OP_INS_LAST  = 4'd0,
        OP_INS_FIRST = 4'd1,
        OP_INS_AT    = 4'd2,
        OP_DEL_LAST  = 4'd3,
        OP_DEL_FIRST = 4'd4,
        OP_DEL_AT    = 4'd5,
        OP_SORT_UP   = 4'd6,
        OP_SORT_DOWN = 4'd7,
        OP_READ      = 4'd8
    } op_code_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD = 3'd0,
        CELL_INS  = 3'd1,
        CELL_DEL  = 3'd2,
        CELL_SORT = 3'd3,
        CELL_ROT  = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic             desc;
        logic             phase;
        logic [IDX_W-1:0] pos;
        logic [IDX_W-1:0] count;
    } cell_cmd_t;

endpackage

@@ rtl/core/ordered_array_list_engine_top.sv @@
// Status results (inserts, deletes, sorts, unknown codes, empty read) appear in the cycle after
// the request is taken. A sort then keeps the chain busy for CAPACITY compare-exchange rounds,
// and a read rotates the cell chain count times, one entry per cycle unless a pending result
// stalls on out_ready; no request is taken until either is done. The read request moves the
// state register to S_READ, from which the min(count, 32) results are registered in turn.
// Reset clears the count, the control state and the output valid; cell contents are not reset.
`include "ordered_array_list_engine_top_macros.svh"

module ordered_array_list_engine_top
    import oale_pkg::*;
#(
    parameter int CAPACITY      = 32,
    parameter int ELEMENT_WIDTH = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [OP_W-1:0]              operation,
    input  logic [POS_W-1:0]             position,
    input  logic signed [IN_VALUE_W-1:0] value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [STATUS_W-1:0]          status,
    output logic [COUNT_W-1:0]           count,
    output logic [EIDX_W-1:0]            element_index,
    output logic signed [OUT_ELEM_W-1:0] element,
    output logic                         last
);

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SORT = 3'b010,
        S_READ = 3'b100
    } state_t;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            step_reg, step_next;
    logic                     desc_reg, desc_next;
    logic                     out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic [COUNT_W-1:0]       count_out_reg, count_out_next;
    logic [EIDX_W-1:0]        eidx_reg, eidx_next;
    logic [OUT_ELEM_W-1:0]    elem_reg, elem_next;
    logic                     last_reg, last_next;

    cell_cmd_t                cmd;
    logic [ELEMENT_WIDTH-1:0] value_ext;
    logic [ELEMENT_WIDTH-1:0] cell_data [CAPACITY];

    logic                     slot_free;
    logic                     in_accept;
    logic [IDX_W-1:0]         cnt;
    logic [IDX_W-1:0]         posx;
    logic [IDX_W-1:0]         step_x;
    logic [IDX_W-1:0]         read_n;
    logic                     full;
    logic                     empty;
    logic                     emit;

    assign value_ext = ELEMENT_WIDTH'(value);
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && slot_free;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        cnt    = IDX_W'(count_reg);
        posx   = IDX_W'(position);
        step_x = IDX_W'(step_reg);
        read_n = (cnt < IDX_W'(READ_LIMIT)) ? cnt : IDX_W'(READ_LIMIT);
        full   = (count_reg >= CW'(CAPACITY));
        empty  = (count_reg == '0);
        emit   = (step_x < IDX_W'(READ_LIMIT));

        state_next     = state_reg;
        count_next     = count_reg;
        step_next      = step_reg;
        desc_next      = desc_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        count_out_next = count_out_reg;
        eidx_next      = eidx_reg;
        elem_next      = elem_reg;
        last_next      = last_reg;

        cmd.op    = CELL_HOLD;
        cmd.desc  = desc_reg;
        cmd.phase = step_reg[0];
        cmd.pos   = cnt;
        cmd.count = cnt;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    status_next = STAT_OK;
                    eidx_next   = '0;
                    elem_next   = '0;
                    last_next   = 1'b1;
                    step_next   = '0;
                    unique case (operation)
                        OP_INS_LAST, OP_INS_FIRST, OP_INS_AT:
                        begin
                            cmd.pos = (operation == OP_INS_LAST)  ? cnt :
                                      (operation == OP_INS_FIRST) ? '0  : posx;
                            if (full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else if (cmd.pos > cnt)
                            begin
                                status_next = STAT_RANGE;
                            end
                            else
                            begin
                                cmd.op     = CELL_INS;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_DEL_LAST, OP_DEL_FIRST, OP_DEL_AT:
                        begin
                            cmd.pos = (operation == OP_DEL_LAST)  ? cnt - IDX_W'(1) :
                                      (operation == OP_DEL_FIRST) ? '0 : posx;
                            if (empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else if (cmd.pos >= cnt)
                            begin
                                status_next = STAT_RANGE;
                            end
                            else
                            begin
                                cmd.op     = CELL_DEL;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        OP_SORT_UP, OP_SORT_DOWN:
                        begin
                            desc_next  = (operation == OP_SORT_DOWN);
                            state_next = S_SORT;
                        end
                        OP_READ:
                        begin
                            if (empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            status_next = STAT_OK;
                        end
                    endcase
                    out_valid_next = !((operation == OP_READ) && !empty);
                    count_out_next = COUNT_W'(count_next);
                end
            end
            S_SORT:
            begin
                cmd.op    = CELL_SORT;
                step_next = step_reg + CW'(1);
                if (step_reg == CW'(CAPACITY - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                if (!emit || slot_free)
                begin
                    cmd.op    = CELL_ROT;
                    step_next = step_reg + CW'(1);
                    if (emit)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = STAT_OK;
                        count_out_next = COUNT_W'(count_reg);
                        eidx_next      = EIDX_W'(step_reg);
                        elem_next      = OUT_ELEM_W'(signed'(cell_data[0]));
                        last_next      = ((step_x + IDX_W'(1)) == read_n);
                    end
                    if ((step_x + IDX_W'(1)) == cnt)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            oale_cell #(
                .INDEX         (gi),
                .ELEMENT_WIDTH (ELEMENT_WIDTH)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .value_in   (value_ext),
                .left_data  (cell_data[(gi == 0) ? 0 : gi - 1]),
                .right_data (cell_data[(gi == CAPACITY - 1) ? gi : gi + 1]),
                .head_data  (cell_data[0]),
                .data       (cell_data[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            desc_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            desc_reg      <= desc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        count_out_reg <= count_out_next;
        eidx_reg      <= eidx_next;
        elem_reg      <= elem_next;
        last_reg      <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign count         = count_out_reg;
    assign element_index = eidx_reg;
    assign element       = signed'(elem_reg);
    assign last          = last_reg;

    `OALE_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(CAPACITY), "count above capacity")
    `OALE_ASSERT_NEXT(a_count_hold, !in_accept, $stable(count_reg), "count moved without request")
    `OALE_ASSERT_NOW(a_multi_only_read, out_valid && !last, state_reg == S_READ,
        "non-final result outside read")
    `OALE_ASSERT_NEXT(a_sort_enter, in_accept && (operation == OP_SORT_UP ||
        operation == OP_SORT_DOWN), state_reg == S_SORT, "sort request did not start sort")

endmodule

@@ rtl/core/oale_cell.sv @@
module oale_cell
    import oale_pkg::*;
#(
    parameter int INDEX         = 0,
    parameter int ELEMENT_WIDTH = 32
)
(
    input  logic                     clk,
    input  cell_cmd_t                cmd,
    input  logic [ELEMENT_WIDTH-1:0] value_in,
    input  logic [ELEMENT_WIDTH-1:0] left_data,
    input  logic [ELEMENT_WIDTH-1:0] right_data,
    input  logic [ELEMENT_WIDTH-1:0] head_data,
    output logic [ELEMENT_WIDTH-1:0] data
);

    localparam logic [IDX_W-1:0] IDX    = IDX_W'(INDEX);
    localparam logic [IDX_W-1:0] IDX_P1 = IDX_W'(INDEX + 1);

    logic [ELEMENT_WIDTH-1:0] data_reg;
    logic [ELEMENT_WIDTH-1:0] data_next;
    logic                     left_role;
    logic                     right_role;
    logic                     take_right;
    logic                     take_left;

    always_comb
    begin
        left_role  = (IDX[0] == cmd.phase) && (IDX_P1 < cmd.count);
        right_role = (IDX[0] != cmd.phase) && (INDEX > 0) && (IDX < cmd.count);
        take_right = cmd.desc ? ($signed(right_data) > $signed(data_reg))
                              : ($signed(data_reg) > $signed(right_data));
        take_left  = cmd.desc ? ($signed(data_reg) > $signed(left_data))
                              : ($signed(left_data) > $signed(data_reg));
        data_next  = data_reg;
        unique case (cmd.op)
            CELL_HOLD:
            begin
                data_next = data_reg;
            end
            CELL_INS:
            begin
                if (IDX == cmd.pos)
                begin
                    data_next = value_in;
                end
                else if (IDX > cmd.pos)
                begin
                    data_next = left_data;
                end
            end
            CELL_DEL:
            begin
                if (IDX >= cmd.pos)
                begin
                    data_next = right_data;
                end
            end
            CELL_SORT:
            begin
                if (left_role && take_right)
                begin
                    data_next = right_data;
                end
                else if (right_role && take_left)
                begin
                    data_next = left_data;
                end
            end
            CELL_ROT:
            begin
                if (IDX_P1 == cmd.count)
                begin
                    data_next = head_data;
                end
                else if (IDX_P1 < cmd.count)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
